### design/tf_pkg.sv
package tf_pkg;

  localparam int INDEX_BITS = 16;
  localparam int COMP_BITS  = 16;
  localparam int UNIT_FRAC  = COMP_BITS - 2;

  // edge and uv deltas, their products, and the raw tangent
  localparam int EDGE_W = COMP_BITS + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int RAW_W  = PROD_W + 1;
  localparam int POS_W  = $clog2(RAW_W);

  // normalized magnitudes carry their top bit at NORM_TOP
  localparam int NORM_TOP = 29;
  localparam int MAG_W    = NORM_TOP + 1;
  localparam int SQR_W    = 2 * MAG_W;
  localparam int SQ_W     = SQR_W + 2;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int REM_W    = ROOT_W + 2;

  // quotient of one tangent component, at most 2^UNIT_FRAC
  localparam int QUO_W = UNIT_FRAC + 1;
  localparam int DVD_W = MAG_W + QUO_W;

  localparam int VEC_W = 3 * COMP_BITS;
  localparam int CRS_W = 2 * COMP_BITS + 1;

  typedef logic [2:0][MAG_W-1:0] mag3_t;
  typedef logic [2:0][QUO_W-1:0] quo3_t;

  // per-triangle data that rides alongside the datapath
  typedef struct packed {
    logic [INDEX_BITS-1:0] ia;
    logic [INDEX_BITS-1:0] ib;
    logic [INDEX_BITS-1:0] ic;
    logic [VEC_W-1:0]      nrm;
    logic [2:0]            neg;
    logic                  deg;
  } side_t;

  // signed component of a packed vector, x in the lowest bits
  function automatic logic signed [COMP_BITS-1:0] comp(input logic [VEC_W-1:0] v,
                                                       input int unsigned slot);
    return v[slot*COMP_BITS +: COMP_BITS];
  endfunction

  // round half up by UNIT_FRAC bits, then saturate to a component
  function automatic logic [COMP_BITS-1:0] round_sat(input logic signed [CRS_W-1:0] d);
    logic signed [CRS_W:0] s;
    logic signed [CRS_W:0] hi;
    logic signed [CRS_W:0] lo;
    s  = ((CRS_W+1)'(d) + (CRS_W+1)'(1 << (UNIT_FRAC - 1))) >>> UNIT_FRAC;
    hi = (CRS_W+1)'((1 << (COMP_BITS - 1)) - 1);
    lo = -hi - (CRS_W+1)'(1);
    if (s > hi) return COMP_BITS'(hi);
    else if (s < lo) return COMP_BITS'(lo);
    else return COMP_BITS'(s);
  endfunction

endpackage

### design/triangle_tangent_frame.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  index_a..c, pos_a..c, uv_a..c, normal_a
// out      output     out_valid / out_ready out_index_a..c, tangent_vec, bitangent_vec,
//                                           degenerate
//
// one triangle enters per cycle while the output is not stalled; the stages are 6 front stages,
// 31 square root stages at one root bit each, 16 divider stages and 3 back stages
// the bit-serial square root and divider set the pipeline depth
// rst clears only the valid bits; the datapath registers hold no reset value
// a stall at the output freezes every stage at once, so in_ready is low only
// while a result waits and the last stage is full
module triangle_tangent_frame import tf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [INDEX_BITS-1:0]  index_a,
  input  logic [INDEX_BITS-1:0]  index_b,
  input  logic [INDEX_BITS-1:0]  index_c,
  input  logic [VEC_W-1:0]       pos_a,
  input  logic [VEC_W-1:0]       pos_b,
  input  logic [VEC_W-1:0]       pos_c,
  input  logic [2*COMP_BITS-1:0] uv_a,
  input  logic [2*COMP_BITS-1:0] uv_b,
  input  logic [2*COMP_BITS-1:0] uv_c,
  input  logic [VEC_W-1:0]       normal_a,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [INDEX_BITS-1:0]  out_index_a,
  output logic [INDEX_BITS-1:0]  out_index_b,
  output logic [INDEX_BITS-1:0]  out_index_c,
  output logic [VEC_W-1:0]       tangent_vec,
  output logic [VEC_W-1:0]       bitangent_vec,
  output logic                   degenerate
);

  logic en;
  logic s_valid, r_valid, q_valid;
  logic [SQ_W-1:0] s_sum;
  logic [ROOT_W-1:0] r_root;
  mag3_t s_mag, r_mag;
  quo3_t q_quo;
  side_t s_side, r_side, q_side;

  // whole pipeline advances unless a finished result is held
  assign en       = out_ready | ~out_valid;
  assign in_ready = en;

  tf_front u_front (
    .clk, .rst, .en, .in_valid,
    .index_a, .index_b, .index_c,
    .pos_a, .pos_b, .pos_c,
    .uv_a, .uv_b, .uv_c,
    .normal_a,
    .s_valid, .s_sum, .s_mag, .s_side
  );

  tf_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid(s_valid), .in_sum(s_sum), .in_mag(s_mag), .in_side(s_side),
    .r_valid, .r_root, .r_mag, .r_side
  );

  tf_div u_div (
    .clk, .rst, .en,
    .in_valid(r_valid), .in_root(r_root), .in_mag(r_mag), .in_side(r_side),
    .q_valid, .q_quo, .q_side
  );

  tf_back u_back (
    .clk, .rst, .en,
    .in_valid(q_valid), .in_quo(q_quo), .in_side(q_side),
    .o_valid(out_valid),
    .o_index_a(out_index_a), .o_index_b(out_index_b), .o_index_c(out_index_c),
    .o_tangent(tangent_vec), .o_bitangent(bitangent_vec),
    .o_degenerate(degenerate)
  );

  // degenerate triangles carry zero vectors
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> tangent_vec == '0 && bitangent_vec == '0)
    else $error("degenerate result with nonzero vectors");

  // a good triangle always has a nonzero unit tangent
  a_tan_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> tangent_vec != '0)
    else $error("zero tangent on a good triangle");

  // the quotient never exceeds one in unit fraction
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_side.deg |-> q_quo[0] <= QUO_W'(1 << UNIT_FRAC) &&
      q_quo[1] <= QUO_W'(1 << UNIT_FRAC) && q_quo[2] <= QUO_W'(1 << UNIT_FRAC))
    else $error("tangent quotient out of range");

  // a held result keeps the input side closed
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

endmodule

### design/tf_front.sv
module tf_front import tf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [INDEX_BITS-1:0] index_a,
  input  logic [INDEX_BITS-1:0] index_b,
  input  logic [INDEX_BITS-1:0] index_c,
  input  logic [VEC_W-1:0]      pos_a,
  input  logic [VEC_W-1:0]      pos_b,
  input  logic [VEC_W-1:0]      pos_c,
  input  logic [2*COMP_BITS-1:0] uv_a,
  input  logic [2*COMP_BITS-1:0] uv_b,
  input  logic [2*COMP_BITS-1:0] uv_c,
  input  logic [VEC_W-1:0]      normal_a,
  output logic                  s_valid,
  output logic [SQ_W-1:0]       s_sum,
  output mag3_t                 s_mag,
  output side_t                 s_side
);

  logic [6:1] v;
  side_t sd1, sd2, sd3, sd4, sd5;

  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [EDGE_W-1:0] du1, dv1, du2, dv2;
  logic signed [PROD_W-1:0] pd1, pd2;
  logic signed [PROD_W-1:0] pa [3];
  logic signed [PROD_W-1:0] pb [3];
  logic [RAW_W-1:0] mag [3];
  mag3_t m4;
  logic [SQR_W-1:0] sq [3];

  logic signed [RAW_W-1:0] det_c;
  logic signed [RAW_W-1:0] raw_c [3];
  logic [RAW_W-1:0] orv;
  logic [POS_W-1:0] top_pos;
  logic [RAW_W+NORM_TOP-1:0] wide [3];

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], in_valid};
    end
  end

  // stage 1: edges and uv deltas
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= EDGE_W'(comp(pos_b, k)) - EDGE_W'(comp(pos_a, k));
        e2[k] <= EDGE_W'(comp(pos_c, k)) - EDGE_W'(comp(pos_a, k));
      end
      du1 <= EDGE_W'(comp(VEC_W'(uv_b), 0)) - EDGE_W'(comp(VEC_W'(uv_a), 0));
      dv1 <= EDGE_W'(comp(VEC_W'(uv_b), 1)) - EDGE_W'(comp(VEC_W'(uv_a), 1));
      du2 <= EDGE_W'(comp(VEC_W'(uv_c), 0)) - EDGE_W'(comp(VEC_W'(uv_a), 0));
      dv2 <= EDGE_W'(comp(VEC_W'(uv_c), 1)) - EDGE_W'(comp(VEC_W'(uv_a), 1));
      sd1.ia  <= index_a;
      sd1.ib  <= index_b;
      sd1.ic  <= index_c;
      sd1.nrm <= normal_a;
      sd1.neg <= '0;
      sd1.deg <= 1'b0;
    end
  end

  // stage 2: determinant and tangent products
  always_ff @(posedge clk) begin
    if (en) begin
      pd1 <= du1 * dv2;
      pd2 <= du2 * dv1;
      for (int k = 0; k < 3; k++) begin
        pa[k] <= dv2 * e1[k];
        pb[k] <= dv1 * e2[k];
      end
      sd2 <= sd1;
    end
  end

  // stage 3: raw tangent with the determinant sign folded in
  always_comb begin
    det_c = RAW_W'(pd1) - RAW_W'(pd2);
    for (int k = 0; k < 3; k++) begin
      raw_c[k] = RAW_W'(pa[k]) - RAW_W'(pb[k]);
      if (det_c < 0) raw_c[k] = -raw_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag[k]     <= raw_c[k][RAW_W-1] ? RAW_W'(-raw_c[k]) : RAW_W'(raw_c[k]);
        sd3.neg[k] <= raw_c[k][RAW_W-1];
      end
      sd3.ia  <= sd2.ia;
      sd3.ib  <= sd2.ib;
      sd3.ic  <= sd2.ic;
      sd3.nrm <= sd2.nrm;
      sd3.deg <= (det_c == '0) ||
                 ((raw_c[0] == '0) && (raw_c[1] == '0) && (raw_c[2] == '0));
    end
  end

  // stage 4: leading one of the largest magnitude sets the scaling shift
  always_comb begin
    orv     = mag[0] | mag[1] | mag[2];
    top_pos = '0;
    for (int i = 0; i < RAW_W; i++) begin
      if (orv[i]) top_pos = POS_W'(i);
    end
    for (int k = 0; k < 3; k++) begin
      wide[k] = {mag[k], {NORM_TOP{1'b0}}} >> top_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m4[k] <= wide[k][MAG_W-1:0];
      end
      sd4 <= sd3;
    end
  end

  // stage 5: squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] <= m4[k] * m4[k];
      end
      sd5 <= sd4;
    end
  end

  // stage 6: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      s_sum  <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
      s_side <= sd5;
    end
  end

  // magnitudes wait two stages beside the squares
  mag3_t m5;
  always_ff @(posedge clk) begin
    if (en) begin
      m5    <= m4;
      s_mag <= m5;
    end
  end

  assign s_valid = v[6];

endmodule

### design/tf_sqrt.sv
module tf_sqrt import tf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_sum,
  input  mag3_t             in_mag,
  input  side_t             in_side,
  output logic              r_valid,
  output logic [ROOT_W-1:0] r_root,
  output mag3_t             r_mag,
  output side_t             r_side
);

  logic              v   [ROOT_W+1];
  logic [SQ_W-1:0]   sh  [ROOT_W+1];
  logic [REM_W-1:0]  rem [ROOT_W+1];
  logic [ROOT_W-1:0] rt  [ROOT_W+1];
  mag3_t             mg  [ROOT_W+1];
  side_t             sd  [ROOT_W+1];

  assign v[0]   = in_valid;
  assign sh[0]  = in_sum;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign mg[0]  = in_mag;
  assign sd[0]  = in_side;

  // one root bit per stage, two radicand bits shifted in each time
  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [REM_W+1:0]  cat;
    logic [REM_W+1:0]  trial;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] rt_next;

    always_comb begin
      cat   = {rem[j], sh[j][SQ_W-1:SQ_W-2]};
      trial = (REM_W+2)'({rt[j], 2'b01});
      if (cat >= trial) begin
        rem_next = REM_W'(cat - trial);
        rt_next  = {rt[j][ROOT_W-2:0], 1'b1};
      end else begin
        rem_next = REM_W'(cat);
        rt_next  = {rt[j][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sh[j+1]  <= sh[j] << 2;
        rem[j+1] <= rem_next;
        rt[j+1]  <= rt_next;
        mg[j+1]  <= mg[j];
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign r_valid = v[ROOT_W];
  assign r_root  = rt[ROOT_W];
  assign r_mag   = mg[ROOT_W];
  assign r_side  = sd[ROOT_W];

endmodule

### design/tf_div.sv
module tf_div import tf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_root,
  input  mag3_t             in_mag,
  input  side_t             in_side,
  output logic              q_valid,
  output quo3_t             q_quo,
  output side_t             q_side
);

  logic                          v   [QUO_W+1];
  logic [ROOT_W-1:0]             dv  [QUO_W+1];
  logic [2:0][ROOT_W-1:0]        rem [QUO_W+1];
  logic [2:0][QUO_W-1:0]         lo  [QUO_W+1];
  side_t                         sd  [QUO_W+1];
  logic [DVD_W-1:0]              dvd [3];

  // rounded dividend: magnitude scaled to the unit fraction plus half the norm
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dvd[k] = (DVD_W'(in_mag[k]) << UNIT_FRAC) + DVD_W'(in_root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rem[0][k] <= ROOT_W'(dvd[k][DVD_W-1:QUO_W]);
        lo[0][k]  <= dvd[k][QUO_W-1:0];
      end
      dv[0] <= in_root;
      sd[0] <= in_side;
    end
  end

  // restoring division, one quotient bit per stage in three lanes
  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [2:0][ROOT_W:0]   cat;
    logic [2:0][ROOT_W-1:0] rem_next;
    logic [2:0][QUO_W-1:0]  lo_next;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        cat[k] = {rem[j][k], lo[j][k][QUO_W-1]};
        if (cat[k] >= (ROOT_W+1)'(dv[j])) begin
          rem_next[k] = ROOT_W'(cat[k] - (ROOT_W+1)'(dv[j]));
          lo_next[k]  = {lo[j][k][QUO_W-2:0], 1'b1};
        end else begin
          rem_next[k] = ROOT_W'(cat[k]);
          lo_next[k]  = {lo[j][k][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= rem_next;
        lo[j+1]  <= lo_next;
        dv[j+1]  <= dv[j];
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign q_valid = v[QUO_W];
  assign q_quo   = lo[QUO_W];
  assign q_side  = sd[QUO_W];

endmodule

### design/tf_back.sv
module tf_back import tf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  quo3_t                 in_quo,
  input  side_t                 in_side,
  output logic                  o_valid,
  output logic [INDEX_BITS-1:0] o_index_a,
  output logic [INDEX_BITS-1:0] o_index_b,
  output logic [INDEX_BITS-1:0] o_index_c,
  output logic [VEC_W-1:0]      o_tangent,
  output logic [VEC_W-1:0]      o_bitangent,
  output logic                  o_degenerate
);

  logic [3:1] v;
  side_t sd1, sd2;
  logic signed [COMP_BITS-1:0] t1 [3];
  logic signed [COMP_BITS-1:0] t2 [3];
  logic signed [COMP_BITS-1:0] nx, ny, nz;
  logic signed [2*COMP_BITS-1:0] pr [6];
  logic signed [CRS_W-1:0] cx, cy, cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:1], in_valid};
    end
  end

  // stage 1: signed tangent components
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t1[k] <= in_side.neg[k] ? -COMP_BITS'(in_quo[k]) : COMP_BITS'(in_quo[k]);
      end
      sd1 <= in_side;
    end
  end

  // stage 2: cross product terms
  assign nx = comp(sd1.nrm, 0);
  assign ny = comp(sd1.nrm, 1);
  assign nz = comp(sd1.nrm, 2);

  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= ny * t1[2];
      pr[1] <= nz * t1[1];
      pr[2] <= nz * t1[0];
      pr[3] <= nx * t1[2];
      pr[4] <= nx * t1[1];
      pr[5] <= ny * t1[0];
      t2    <= t1;
      sd2   <= sd1;
    end
  end

  // stage 3: round, saturate and zero degenerate triangles into the output register
  assign cx = CRS_W'(pr[0]) - CRS_W'(pr[1]);
  assign cy = CRS_W'(pr[2]) - CRS_W'(pr[3]);
  assign cz = CRS_W'(pr[4]) - CRS_W'(pr[5]);

  always_ff @(posedge clk) begin
    if (en) begin
      o_index_a    <= sd2.ia;
      o_index_b    <= sd2.ib;
      o_index_c    <= sd2.ic;
      o_degenerate <= sd2.deg;
      if (sd2.deg) begin
        o_tangent   <= '0;
        o_bitangent <= '0;
      end else begin
        o_tangent   <= {t2[2], t2[1], t2[0]};
        o_bitangent <= {round_sat(cz), round_sat(cy), round_sat(cx)};
      end
    end
  end

  assign o_valid = v[3];

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tf_pkg::*;

  typedef struct {
    logic [INDEX_BITS-1:0]  ia, ib, ic;
    logic [VEC_W-1:0]       pa, pb, pc, nrm;
    logic [2*COMP_BITS-1:0] ua, ub, uc;
  } triangle_t;

  typedef struct {
    logic [INDEX_BITS-1:0] ia, ib, ic;
    logic [VEC_W-1:0]      tng, btg;
    logic                  deg;
  } frame_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [INDEX_BITS-1:0]  index_a, index_b, index_c;
  logic [VEC_W-1:0]       pos_a, pos_b, pos_c, normal_a;
  logic [2*COMP_BITS-1:0] uv_a, uv_b, uv_c;
  logic [INDEX_BITS-1:0]  out_index_a, out_index_b, out_index_c;
  logic [VEC_W-1:0]       tangent_vec, bitangent_vec;
  logic                   degenerate;

  triangle_t tri_queue[$];
  frame_t    frame_queue[$];
  int        send_idle_pct, recv_stall_pct, hold_cycles;
  int        errors, n_in, n_out, n_deg;
  bit        in_taken;

  triangle_tangent_frame dut (.*);

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // sign-extended component of a packed vector
  function automatic longint comp_at(logic [VEC_W-1:0] v, int slot);
    logic [COMP_BITS-1:0] c;
    c = v[slot*COMP_BITS +: COMP_BITS];
    return longint'($signed(c));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp_comp(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (COMP_BITS - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // expected tangent frame of one triangle
  function automatic frame_t tangent_frame(triangle_t t);
    frame_t f;
    longint e1[3], e2[3], raw[3], nv[3], tg[3], bt[3];
    longint unsigned mg[3], top, sq, n, q;
    longint a, du1, dv1, du2, dv2, det;
    int p;
    for (int k = 0; k < 3; k++) begin
      a = comp_at(t.pa, k);
      e1[k] = comp_at(t.pb, k) - a;
      e2[k] = comp_at(t.pc, k) - a;
      nv[k] = comp_at(t.nrm, k);
      tg[k] = 0;
      bt[k] = 0;
    end
    du1 = comp_at(t.ub, 0) - comp_at(t.ua, 0);
    dv1 = comp_at(t.ub, 1) - comp_at(t.ua, 1);
    du2 = comp_at(t.uc, 0) - comp_at(t.ua, 0);
    dv2 = comp_at(t.uc, 1) - comp_at(t.ua, 1);
    det = du1 * dv2 - du2 * dv1;
    top = 0;
    for (int k = 0; k < 3; k++) begin
      raw[k] = dv2 * e1[k] - dv1 * e2[k];
      if (det < 0) raw[k] = -raw[k];
      mg[k] = raw[k] < 0 ? longint'(-raw[k]) : raw[k];
      if (mg[k] > top) top = mg[k];
    end
    f.deg = (det == 0) || (top == 0);
    if (!f.deg) begin
      p = 63;
      while (p > 0 && top[p] == 1'b0) p--;
      for (int k = 0; k < 3; k++)
        mg[k] = p > NORM_TOP ? mg[k] >> (p - NORM_TOP) : mg[k] << (NORM_TOP - p);
      sq = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
      n = int_sqrt(sq);
      if (n == 0) n = 1;
      for (int k = 0; k < 3; k++) begin
        q = ((mg[k] << UNIT_FRAC) + (n >> 1)) / n;
        tg[k] = raw[k] < 0 ? -longint'(q) : longint'(q);
      end
      bt[0] = clamp_comp((nv[1] * tg[2] - nv[2] * tg[1] + (64'sd1 <<< (UNIT_FRAC - 1)))
                         >>> UNIT_FRAC);
      bt[1] = clamp_comp((nv[2] * tg[0] - nv[0] * tg[2] + (64'sd1 <<< (UNIT_FRAC - 1)))
                         >>> UNIT_FRAC);
      bt[2] = clamp_comp((nv[0] * tg[1] - nv[1] * tg[0] + (64'sd1 <<< (UNIT_FRAC - 1)))
                         >>> UNIT_FRAC);
      for (int k = 0; k < 3; k++) tg[k] = clamp_comp(tg[k]);
    end
    f.ia = t.ia;
    f.ib = t.ib;
    f.ic = t.ic;
    for (int k = 0; k < 3; k++) begin
      f.tng[k*COMP_BITS +: COMP_BITS] = tg[k][COMP_BITS-1:0];
      f.btg[k*COMP_BITS +: COMP_BITS] = bt[k][COMP_BITS-1:0];
    end
    return f;
  endfunction

  function automatic logic [VEC_W-1:0] vec3(int x, int y, int z);
    return {z[COMP_BITS-1:0], y[COMP_BITS-1:0], x[COMP_BITS-1:0]};
  endfunction

  function automatic logic [2*COMP_BITS-1:0] uv2(int u, int v);
    return {v[COMP_BITS-1:0], u[COMP_BITS-1:0]};
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec(bit tiny);
    if (tiny) return vec3($urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(8) - 4);
    return VEC_W'({$urandom, $urandom});
  endfunction

  // random triangle: mostly well formed, some degenerate or near it
  function automatic triangle_t rand_triangle();
    triangle_t t;
    int kind;
    kind = $urandom_range(99);
    t.ia = INDEX_BITS'($urandom);
    t.ib = INDEX_BITS'($urandom);
    t.ic = INDEX_BITS'($urandom);
    t.pa = rand_vec(kind >= 70 && kind < 80);
    t.pb = rand_vec(kind >= 70 && kind < 80);
    t.pc = rand_vec(kind >= 70 && kind < 80);
    t.ua = $urandom;
    t.ub = $urandom;
    t.uc = $urandom;
    t.nrm = $urandom_range(1) ? rand_vec(0) :
            vec3($urandom_range(32768) - 16384, $urandom_range(32768) - 16384, 16384);
    if (kind >= 70 && kind < 80) begin
      t.ub = uv2($urandom_range(6) - 3, $urandom_range(6) - 3);
      t.uc = uv2($urandom_range(6) - 3, $urandom_range(6) - 3);
      t.ua = '0;
    end
    if (kind >= 80 && kind < 90) t.uc = $urandom_range(1) ? t.ua : t.ub;
    if (kind >= 90) begin
      t.pb = t.pa;
      t.pc = t.pa;
    end
    return t;
  endfunction

  function automatic triangle_t make_triangle(logic [VEC_W-1:0] pa, pb, pc,
                                              logic [2*COMP_BITS-1:0] ua, ub, uc,
                                              logic [VEC_W-1:0] nrm);
    triangle_t t;
    t.ia = INDEX_BITS'($urandom);
    t.ib = INDEX_BITS'($urandom);
    t.ic = INDEX_BITS'($urandom);
    t.pa = pa;
    t.pb = pb;
    t.pc = pc;
    t.ua = ua;
    t.ub = ub;
    t.uc = uc;
    t.nrm = nrm;
    return t;
  endfunction

  // append one triangle to the pending queue
  task automatic add_triangle(triangle_t t);
    tri_queue = {tri_queue, t};
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (tri_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        triangle_t t;
        t = tri_queue.pop_front();
        index_a  <= t.ia;
        index_b  <= t.ib;
        index_c  <= t.ic;
        pos_a    <= t.pa;
        pos_b    <= t.pb;
        pos_c    <= t.pc;
        uv_a     <= t.ua;
        uv_b     <= t.ub;
        uv_c     <= t.uc;
        normal_a <= t.nrm;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long output hold-off counter
  always @(negedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // output ready
  always @(negedge clk) begin
    if (!rst)
      out_ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin
    in_taken = !rst && in_valid && in_ready;
    if (in_taken) begin
      triangle_t t;
      t = '{index_a, index_b, index_c, pos_a, pos_b, pos_c, normal_a, uv_a, uv_b, uv_c};
      frame_queue = {frame_queue, tangent_frame(t)};
      n_in++;
    end
    if (!rst && out_valid && out_ready) begin
      n_out++;
      if (frame_queue.size() == 0) begin
        $error("result with no triangle pending");
        errors++;
      end else begin
        frame_t f;
        f = frame_queue.pop_front();
        if (f.deg) n_deg++;
        if (out_index_a !== f.ia) begin
          $error("out_index_a: expected %h got %h", f.ia, out_index_a);
          errors++;
        end
        if (out_index_b !== f.ib) begin
          $error("out_index_b: expected %h got %h", f.ib, out_index_b);
          errors++;
        end
        if (out_index_c !== f.ic) begin
          $error("out_index_c: expected %h got %h", f.ic, out_index_c);
          errors++;
        end
        if (tangent_vec !== f.tng) begin
          $error("tangent_vec: expected %h got %h", f.tng, tangent_vec);
          errors++;
        end
        if (bitangent_vec !== f.btg) begin
          $error("bitangent_vec: expected %h got %h", f.btg, bitangent_vec);
          errors++;
        end
        if (degenerate !== f.deg) begin
          $error("degenerate: expected %b got %b", f.deg, degenerate);
          errors++;
        end
      end
    end
  end

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) add_triangle(rand_triangle());
    // sender pauses until the pipeline has drained
    wait (tri_queue.size() == 0);
    @(posedge clk);
    while (in_valid || frame_queue.size() > 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    rst = 1;
    in_valid = 0;
    out_ready = 0;
    {index_a, index_b, index_c} = '0;
    {pos_a, pos_b, pos_c, normal_a} = '0;
    {uv_a, uv_b, uv_c} = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    errors = 0;
    n_in = 0;
    n_out = 0;
    n_deg = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: all zero, simple quad, negative det, extremes, parallel normal
    add_triangle(make_triangle('0, '0, '0, '0, '0, '0, '0));
    add_triangle(make_triangle(vec3(0, 0, 0), vec3(2048, 0, 0), vec3(0, 2048, 0),
                               uv2(0, 0), uv2(16384, 0), uv2(0, 16384),
                               vec3(0, 0, 16384)));
    add_triangle(make_triangle(vec3(0, 0, 0), vec3(2048, 0, 0), vec3(0, 2048, 0),
                               uv2(0, 0), uv2(0, 16384), uv2(16384, 0),
                               vec3(0, 0, 16384)));
    add_triangle(make_triangle(vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767),
                               vec3(32767, -32768, 32767), uv2(-32768, -32768),
                               uv2(32767, -32768), uv2(-32768, 32767),
                               vec3(32767, 32767, 32767)));
    add_triangle(make_triangle(vec3(32767, 32767, 32767), vec3(-32768, 0, 0),
                               vec3(0, -32768, 0), uv2(32767, 32767),
                               uv2(-32768, 32767), uv2(32767, -32768),
                               vec3(-32768, -32768, -32768)));
    // normal along the tangent gives a zero bitangent
    add_triangle(make_triangle(vec3(0, 0, 0), vec3(2048, 0, 0), vec3(0, 2048, 0),
                               uv2(0, 0), uv2(16384, 0), uv2(0, 16384),
                               vec3(16384, 0, 0)));
    // zero determinant with collinear uvs
    add_triangle(make_triangle(vec3(0, 0, 0), vec3(100, 0, 0), vec3(0, 100, 0),
                               uv2(0, 0), uv2(100, 100), uv2(200, 200),
                               vec3(0, 0, 16384)));
    // zero raw tangent with nonzero det
    add_triangle(make_triangle(vec3(5, 5, 5), vec3(5, 5, 5), vec3(5, 5, 5),
                               uv2(0, 0), uv2(16384, 0), uv2(0, 16384),
                               vec3(0, 0, 16384)));
    // tiny tangent, shifted up
    add_triangle(make_triangle(vec3(0, 0, 0), vec3(1, 0, 0), vec3(0, 1, 0),
                               uv2(0, 0), uv2(1, 0), uv2(0, 1), vec3(0, 0, 16384)));
    // huge non-unit normal drives a bitangent component to the bottom of its range
    add_triangle(make_triangle(vec3(0, 0, 0), vec3(2048, 0, 0), vec3(0, 0, 2048),
                               uv2(0, 0), uv2(16384, 0), uv2(0, 16384),
                               vec3(-32768, 32767, -32768)));
    for (int i = 0; i < 8; i++) add_triangle(rand_triangle());
    tri_queue[0].ia = '1;
    tri_queue[0].ib = '1;
    tri_queue[0].ic = '1;
    run_phase(0, 0, 0);

    run_phase(140, 0, 0);
    run_phase(140, 47, 0);
    run_phase(140, 0, 47);
    run_phase(140, 47, 47);
    // receiver holds off long enough to back up the input
    hold_cycles = 300;
    run_phase(140, 0, 16);
    run_phase(20, 16, 16);

    repeat (60) @(posedge clk);
    $display("covered %0d triangles, %0d results, %0d degenerate", n_in, n_out, n_deg);
    $display("phases: directed, back to back, input gaps, output stalls, both, long hold-off");
    if (errors == 0 && frame_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (frame_queue.size() > 0) $error("%0d results never arrived", frame_queue.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
design/tf_pkg.sv
design/tf_front.sv
design/tf_sqrt.sv
design/tf_div.sv
design/tf_back.sv
design/triangle_tangent_frame.sv
tb/sv/tb_top.sv
